FILE: rtl/core/tde_pkg.sv
package tde_pkg;

  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned EpochW = 32;
  localparam int unsigned TodW   = 17;

  localparam logic [YearW-1:0]  EpochYear   = 12'd1970;
  localparam logic [1:0]        EpochMod4   = 2'd2;
  localparam logic [6:0]        EpochMod100 = 7'd70;
  localparam logic [8:0]        EpochMod400 = 9'd370;
  localparam logic [6:0]        LastMod100  = 7'd99;
  localparam logic [8:0]        LastMod400  = 9'd399;
  localparam logic [8:0]        Cycle400    = 9'd400;
  localparam logic [6:0]        Cycle100    = 7'd100;
  localparam logic [8:0]        DaysLeap    = 9'd366;
  localparam logic [8:0]        DaysCommon  = 9'd365;
  localparam logic [4:0]        FebLeapDays = 5'd29;
  localparam logic [MonthW-1:0] MonthFeb    = 4'd2;
  localparam logic [MonthW-1:0] MonthFirst  = 4'd1;
  localparam logic [MonthW-1:0] MonthStop   = 4'd13;

  localparam logic [16:0] SecPerDay   = 17'd86400;
  localparam logic [11:0] SecPerHour  = 12'd3600;
  localparam logic [6:0]  SecPerMin   = 7'd60;
  localparam logic [6:0]  MinPerHour  = 7'd60;
  localparam logic [5:0]  HourPerDay  = 6'd24;

  typedef enum logic {
    CmdTick = 1'b0,
    CmdLoad = 1'b1
  } tde_cmd_e;

  typedef struct packed {
    logic              start;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
  } tde_load_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tde_sts_t;

  function automatic logic [4:0] month_len(logic [MonthW-1:0] m);
    logic [4:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/core/tde_in_if.sv
interface tde_in_if;
  import tde_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [YearW-1:0]  year;
  logic [MonthW-1:0] month;
  logic [DayW-1:0]   day;
  logic [HourW-1:0]  hour;
  logic [MinW-1:0]   minute;
  logic [SecW-1:0]   second;

  modport source (output valid, cmd, year, month, day, hour, minute, second, input ready);
  modport sink (input valid, cmd, year, month, day, hour, minute, second, output ready);
endinterface

FILE: rtl/core/tde_out_if.sv
interface tde_out_if;
  import tde_pkg::*;

  logic              valid;
  logic              ready;
  logic [HourW-1:0]  cur_hour;
  logic [MinW-1:0]   cur_minute;
  logic [SecW-1:0]   cur_second;
  logic [EpochW-1:0] epoch_seconds;

  modport source (output valid, cur_hour, cur_minute, cur_second, epoch_seconds, input ready);
  modport sink (input valid, cur_hour, cur_minute, cur_second, epoch_seconds, output ready);
endinterface

FILE: rtl/core/tde_alu.sv
module tde_alu (
  input  logic [tde_pkg::EpochW-1:0] a_i,
  input  logic [tde_pkg::EpochW-1:0] b_i,
  input  logic                       sub_i,
  output logic [tde_pkg::EpochW-1:0] res_o,
  output logic                       carry_o
);
  import tde_pkg::*;

  logic [EpochW:0] sum;

  assign sum     = {1'b0, a_i} + {1'b0, (sub_i ? ~b_i : b_i)} + {{EpochW{1'b0}}, sub_i};
  assign res_o   = sum[EpochW-1:0];
  assign carry_o = sum[EpochW];
endmodule

FILE: rtl/core/tde_epoch.sv
module tde_epoch (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tde_pkg::tde_load_t         req_i,
  output tde_pkg::tde_sts_t          sts_o,
  output logic [tde_pkg::EpochW-1:0] epoch_o
);
  import tde_pkg::*;

  typedef enum logic [8:0] {
    StIdle = 9'b000000001,
    StR400 = 9'b000000010,
    StR100 = 9'b000000100,
    StYear = 9'b000001000,
    StMon  = 9'b000010000,
    StDay  = 9'b000100000,
    StMul  = 9'b001000000,
    StTod  = 9'b010000000,
    StDone = 9'b100000000
  } tde_state_e;

  tde_state_e state_q, state_d;

  logic [YearW-1:0]  year_q, rem_q, yr_q;
  logic [DayW-1:0]   day_q;
  logic [HourW-1:0]  hour_q;
  logic [MinW-1:0]   min_q;
  logic [SecW-1:0]   sec_q;
  logic [MonthW-1:0] mon_q, last_q;
  logic [1:0]        m4_q;
  logic [6:0]        m100_q;
  logic [8:0]        m400_q;
  logic              z400_q, leap_y_q;
  logic [EpochW-1:0] acc_q;

  logic [EpochW-1:0] alu_a, alu_b, alu_res;
  logic              alu_sub, alu_carry;
  logic              leap_k, feb_leap;
  logic [TodW-1:0]   h_s, m_s, tod;
  logic [EpochW-1:0] prod;

  tde_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .sub_i  (alu_sub),
    .res_o  (alu_res),
    .carry_o(alu_carry)
  );

  assign leap_k   = (m4_q == 2'd0) && ((m100_q != 7'd0) || (m400_q == 9'd0));
  assign feb_leap = (mon_q == MonthFeb) && leap_y_q;
  assign h_s      = TodW'(hour_q) * TodW'(SecPerHour);
  assign m_s      = TodW'(min_q) * TodW'(SecPerMin);
  assign tod      = h_s + m_s + TodW'(sec_q);
  assign prod     = acc_q * EpochW'(SecPerDay);

  always_comb begin
    alu_a   = acc_q;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      StR400: begin
        alu_a   = EpochW'(rem_q);
        alu_b   = EpochW'(Cycle400);
        alu_sub = 1'b1;
      end
      StR100: begin
        alu_a   = EpochW'(rem_q);
        alu_b   = EpochW'(Cycle100);
        alu_sub = 1'b1;
      end
      StYear:  alu_b = EpochW'(leap_k ? DaysLeap : DaysCommon);
      StMon:   alu_b = EpochW'(feb_leap ? FebLeapDays : month_len(mon_q));
      StDay:   alu_b = EpochW'(day_q) - EpochW'(1);
      StTod:   alu_b = EpochW'(tod);
      default: alu_b = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (req_i.start) state_d = StR400;
      StR400:  if (!alu_carry) state_d = StR100;
      StR100:  if (!alu_carry) state_d = StYear;
      StYear:  if (yr_q >= year_q) state_d = StMon;
      StMon:   if (mon_q >= last_q) state_d = StDay;
      StDay:   state_d = StMul;
      StMul:   state_d = StTod;
      StTod:   state_d = StDone;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (req_i.start) begin
          year_q <= req_i.year;
          rem_q  <= req_i.year;
          day_q  <= req_i.day;
          hour_q <= req_i.hour;
          min_q  <= req_i.minute;
          sec_q  <= req_i.second;
          last_q <= (req_i.month > MonthStop) ? MonthStop : req_i.month;
          mon_q  <= MonthFirst;
          yr_q   <= EpochYear;
          m4_q   <= EpochMod4;
          m100_q <= EpochMod100;
          m400_q <= EpochMod400;
          acc_q  <= '0;
        end
      end
      StR400: begin
        if (alu_carry) begin
          rem_q <= alu_res[YearW-1:0];
        end else begin
          z400_q <= (rem_q == '0);
        end
      end
      StR100: begin
        if (alu_carry) begin
          rem_q <= alu_res[YearW-1:0];
        end else begin
          leap_y_q <= (year_q[1:0] == 2'd0) && ((rem_q != '0) || z400_q);
        end
      end
      StYear: begin
        if (yr_q < year_q) begin
          acc_q  <= alu_res;
          yr_q   <= yr_q + YearW'(1);
          m4_q   <= m4_q + 2'd1;
          m100_q <= (m100_q == LastMod100) ? 7'd0 : m100_q + 7'd1;
          m400_q <= (m400_q == LastMod400) ? 9'd0 : m400_q + 9'd1;
        end
      end
      StMon: begin
        if (mon_q < last_q) begin
          acc_q <= alu_res;
          mon_q <= mon_q + MonthW'(1);
        end
      end
      StDay:   acc_q <= alu_res;
      StMul:   acc_q <= prod;
      StTod:   acc_q <= alu_res;
      default: acc_q <= acc_q;
    endcase
  end

  assign sts_o.busy = (state_q != StIdle);
  assign sts_o.done = (state_q == StDone);
  assign epoch_o    = acc_q;
endmodule

FILE: rtl/core/time_of_day_epoch_clock.sv
// Tick: result is valid in the cycle after the input transfer; one tick per cycle while drained and no load runs.
// Load: one shared 32-bit adder steps over the year, leap test and month loops, one step
//   per cycle, in order: the remainder of the year by 400 and by 100 for the leap test,
//   the years from 1970, the months before the given one, the day, a multiply by 86400
//   seconds and the time of day; no input is taken while the load is in progress.
// Reset: asynchronous, active low; clears time of day, epoch and output valid.
module time_of_day_epoch_clock (
  input  logic      clk_i,
  input  logic      rst_ni,
  tde_in_if.sink    in_i,
  tde_out_if.source out_o
);
  import tde_pkg::*;

  logic [HourW-1:0]  hour_q, hour_d;
  logic [MinW-1:0]   min_q, min_d;
  logic [SecW-1:0]   sec_q, sec_d;
  logic [EpochW-1:0] epoch_q, epoch_d, epoch_res;
  logic              out_valid_q, out_valid_d;
  logic              in_xfer, tick, load;
  logic [SecW:0]     sec_inc;
  logic [MinW:0]     min_inc;
  logic [HourW:0]    hour_inc;
  tde_load_t         req;
  tde_sts_t          sts;

  assign in_i.ready = !sts.busy && (!out_valid_q || out_o.ready);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign tick       = in_xfer && (in_i.cmd == CmdTick);
  assign load       = in_xfer && (in_i.cmd == CmdLoad);

  assign req.start  = load;
  assign req.year   = in_i.year;
  assign req.month  = in_i.month;
  assign req.day    = in_i.day;
  assign req.hour   = in_i.hour;
  assign req.minute = in_i.minute;
  assign req.second = in_i.second;

  tde_epoch u_epoch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .sts_o  (sts),
    .epoch_o(epoch_res)
  );

  assign sec_inc  = {1'b0, sec_q} + (SecW+1)'(1);
  assign min_inc  = {1'b0, min_q} + (MinW+1)'(1);
  assign hour_inc = {1'b0, hour_q} + (HourW+1)'(1);

  always_comb begin
    hour_d      = hour_q;
    min_d       = min_q;
    sec_d       = sec_q;
    epoch_d     = epoch_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (tick) begin
      epoch_d     = epoch_q + EpochW'(1);
      out_valid_d = 1'b1;
      sec_d       = sec_inc[SecW-1:0];
      if (sec_inc >= (SecW+1)'(SecPerMin)) begin
        sec_d = '0;
        min_d = min_inc[MinW-1:0];
        if (min_inc >= (MinW+1)'(MinPerHour)) begin
          min_d  = '0;
          hour_d = hour_inc[HourW-1:0];
          if (hour_inc >= (HourW+1)'(HourPerDay)) begin
            hour_d = '0;
          end
        end
      end
    end else if (load) begin
      hour_d = in_i.hour;
      min_d  = in_i.minute;
      sec_d  = in_i.second;
    end
    if (sts.done) begin
      epoch_d     = epoch_res;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q      <= '0;
      min_q       <= '0;
      sec_q       <= '0;
      epoch_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hour_q      <= hour_d;
      min_q       <= min_d;
      sec_q       <= sec_d;
      epoch_q     <= epoch_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.cur_hour      = hour_q;
  assign out_o.cur_minute    = min_q;
  assign out_o.cur_second    = sec_q;
  assign out_o.epoch_seconds = epoch_q;

  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> out_valid_q)
    else $error("tick transfer gave no result");

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.busy |-> !in_i.ready)
    else $error("input taken during load");

  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.done |-> !out_valid_q)
    else $error("load result would overwrite pending result");

  a_tick_sec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> ({1'b0, sec_q} < SecPerMin))
    else $error("seconds out of range after tick");
endmodule
